/* rtl/qpht_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package qpht_pkg;

   // field widths of the items
   localparam int CMD_W = 2;
   localparam int KEY_W = 31;
   localparam int PAY_W = 32;
   localparam int STATUS_W = 2;

   // default table geometry and probe budget factor
   localparam int TABLE_SLOTS_DEF = 256;
   localparam int PROBE_FACTOR = 4;

   // home slot reduction by reciprocal multiplication, one step a cycle
   localparam int HASH_CYCLES = 4;

   typedef enum logic [CMD_W-1:0] {
      CMD_INSERT = 2'd0,
      CMD_SEARCH = 2'd1,
      CMD_REMOVE = 2'd2
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_DONE   = 2'd0,
      ST_ABSENT = 2'd1,
      ST_DUP    = 2'd2,
      ST_FULL   = 2'd3
   } status_type;

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_CLEAR = 6'b000010,
      S_HASH  = 6'b000100,
      S_READ  = 6'b001000,
      S_CHECK = 6'b010000,
      S_SPARE = 6'b100000
   } state_type;

   // one slot of the table memory
   typedef struct packed {
      logic             used;
      logic [KEY_W-1:0] key;
      logic [PAY_W-1:0] payload;
   } entry_type;

endpackage

`default_nettype wire

/* rtl/quadratic_probe_hash_table.sv */
`timescale 1ns / 1ps
`default_nettype none

// channel | direction | tdata fields (lowest bit up)                         | width
// req     | in        | command[1:0] key[32:2] payload_in[64:33] zero pad     | 72
// rsp     | out       | status[1:0] payload_out[33:2] zero pad                | 40
//
// an item is reduced to its home slot by reciprocal multiply in S_HASH (skipped
// when TABLE_SLOTS is a power of two), then probed; each probe is one memory
// read (S_READ) and one compare (S_CHECK), with at most 4 * TABLE_SLOTS probes
// after reset a clearing pass writes every slot to zero before req_tready rises
// the result register lets the next item start while a result waits on rsp_tready;
// a finished item holds in its last probe while that register is still full

module quadratic_probe_hash_table
   import qpht_pkg::*;
#(
   parameter int TABLE_SLOTS = TABLE_SLOTS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [71:0] req_tdata,   // command, key, payload_in
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [39:0]      rsp_tdata    // status, payload_out
);

   localparam int SLOT_W = $clog2(TABLE_SLOTS);
   localparam int PROBE_LIMIT = PROBE_FACTOR * TABLE_SLOTS;
   localparam int CNT_W = $clog2(PROBE_LIMIT);
   localparam int HCNT_W = $clog2(HASH_CYCLES);
   localparam bit SLOTS_POW2 = (TABLE_SLOTS & (TABLE_SLOTS - 1)) == 0;
   localparam logic [SLOT_W:0] SLOTS_X = (SLOT_W + 1)'(TABLE_SLOTS);
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TABLE_SLOTS - 1);
   localparam logic [CNT_W-1:0] LAST_PROBE = CNT_W'(PROBE_LIMIT - 1);
   localparam logic [HCNT_W-1:0] LAST_HCNT = HCNT_W'(HASH_CYCLES - 1);

   // reciprocal of the slot count, exact quotient for every 31-bit key
   localparam int MUL_SHIFT = KEY_W + SLOT_W;
   localparam logic [32:0] MUL_RECIP = 33'(((64'd1 << MUL_SHIFT) + 64'(TABLE_SLOTS)
                                             - 64'd1) / 64'(TABLE_SLOTS));
   localparam logic [15:0] RECIP_LO = MUL_RECIP[15:0];
   localparam logic [16:0] RECIP_HI = MUL_RECIP[32:16];
   localparam logic [16:0] SLOTS_K = 17'(TABLE_SLOTS);

   // control state
   state_type state_ff, state_in;
   logic [SLOT_W-1:0] clr_ff, clr_in;
   logic [HCNT_W-1:0] hcnt_ff, hcnt_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic rsp_valid_ff, rsp_valid_in;

   // item registers
   cmd_type cmd_ff, cmd_in;
   logic [KEY_W-1:0] key_ff, key_in;
   logic [PAY_W-1:0] pay_ff, pay_in;
   logic [63:0] acc_ff, acc_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [SLOT_W-1:0] step_ff, step_in;
   status_type rsp_status_ff, rsp_status_in;
   logic [PAY_W-1:0] rsp_pay_ff, rsp_pay_in;

   // slot memory
   entry_type slot_mem_ff [TABLE_SLOTS];
   entry_type rd_data_ff;
   logic mem_re;
   logic mem_we;
   logic [SLOT_W-1:0] mem_waddr;
   entry_type mem_wdata;

   logic req_fire;
   logic rsp_free;
   logic rsp_load;

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire = req_tvalid && req_tready;
   assign rsp_free = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {6'd0, rsp_pay_ff, rsp_status_ff};

   // sequencer: clear, reduce key, probe, answer
   always_comb begin
      logic [46:0] prod_lo;
      logic [47:0] prod_hi;
      logic [47:0] prod_q;
      logic [KEY_W-1:0] quo;
      logic [SLOT_W:0] slot_sum;
      logic [SLOT_W:0] step_sum;
      logic fin;
      status_type fin_status;
      logic [PAY_W-1:0] fin_pay;
      logic fin_write;
      entry_type fin_entry;

      state_in = state_ff;
      clr_in = clr_ff;
      hcnt_in = hcnt_ff;
      cnt_in = cnt_ff;
      cmd_in = cmd_ff;
      key_in = key_ff;
      pay_in = pay_ff;
      acc_in = acc_ff;
      slot_in = slot_ff;
      step_in = step_ff;
      rsp_status_in = rsp_status_ff;
      rsp_pay_in = rsp_pay_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_load = 1'b0;
      mem_re = 1'b0;
      mem_we = 1'b0;
      mem_waddr = slot_ff;
      mem_wdata = rd_data_ff;

      // key mod TABLE_SLOTS: quotient by reciprocal, then key minus quotient times slots
      prod_lo = {16'd0, key_ff} * {31'd0, RECIP_LO};
      prod_hi = {17'd0, key_ff} * {31'd0, RECIP_HI};
      quo = KEY_W'(acc_ff >> MUL_SHIFT);
      prod_q = {17'd0, quo} * {31'd0, SLOTS_K};

      // next probe: offset grows by 2i+1 each step
      slot_sum = {1'b0, slot_ff} + {1'b0, step_ff};
      if (slot_sum >= SLOTS_X) begin
         slot_sum = slot_sum - SLOTS_X;
      end
      step_sum = {1'b0, step_ff} + (SLOT_W + 1)'(2);
      if (step_sum >= SLOTS_X) begin
         step_sum = step_sum - SLOTS_X;
      end

      // outcome of the probe in rd_data_ff
      fin = 1'b1;
      fin_status = ST_ABSENT;
      fin_pay = '0;
      fin_write = 1'b0;
      fin_entry = rd_data_ff;
      case (cmd_ff)
         CMD_INSERT: begin
            if (!rd_data_ff.used) begin
               fin_status = ST_DONE;
               fin_write = 1'b1;
               fin_entry.used = 1'b1;
               fin_entry.key = key_ff;
               fin_entry.payload = pay_ff;
            end else if (rd_data_ff.key == key_ff) begin
               fin_status = ST_DUP;
            end else if (cnt_ff == LAST_PROBE) begin
               fin_status = ST_FULL;
            end else begin
               fin = 1'b0;
            end
         end
         CMD_SEARCH, CMD_REMOVE: begin
            if (!rd_data_ff.used) begin
               fin_status = ST_ABSENT;
            end else if (rd_data_ff.key == key_ff) begin
               fin_status = ST_DONE;
               fin_pay = rd_data_ff.payload;
               fin_write = (cmd_ff == CMD_REMOVE);
               fin_entry.used = 1'b0;
            end else if (cnt_ff == LAST_PROBE) begin
               fin_status = ST_ABSENT;
            end else begin
               fin = 1'b0;
            end
         end
         default: begin
            fin_status = ST_ABSENT;
         end
      endcase

      case (state_ff)
         S_CLEAR: begin
            mem_we = 1'b1;
            mem_waddr = clr_ff;
            mem_wdata = '0;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == LAST_SLOT) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_fire) begin
               cmd_in = cmd_type'(req_tdata[1:0]);
               key_in = req_tdata[32:2];
               pay_in = req_tdata[64:33];
               acc_in = '0;
               hcnt_in = '0;
               cnt_in = '0;
               step_in = SLOT_W'(1);
               slot_in = req_tdata[2 +: SLOT_W];
               state_in = SLOTS_POW2 ? S_READ : S_HASH;
            end
         end
         S_HASH: begin
            hcnt_in = hcnt_ff + 1'b1;
            if (hcnt_ff == HCNT_W'(0)) begin
               acc_in = {17'd0, prod_lo};
            end else if (hcnt_ff == HCNT_W'(1)) begin
               acc_in = acc_ff + {prod_hi, 16'd0};
            end else if (hcnt_ff == HCNT_W'(2)) begin
               acc_in = {16'd0, prod_q};
            end
            if (hcnt_ff == LAST_HCNT) begin
               slot_in = SLOT_W'(key_ff - acc_ff[KEY_W-1:0]);
               state_in = S_READ;
            end
         end
         S_READ: begin
            mem_re = 1'b1;
            state_in = S_CHECK;
         end
         S_CHECK: begin
            if (!fin) begin
               slot_in = slot_sum[SLOT_W-1:0];
               step_in = step_sum[SLOT_W-1:0];
               cnt_in = cnt_ff + 1'b1;
               state_in = S_READ;
            end else if (rsp_free) begin
               rsp_load = 1'b1;
               rsp_valid_in = 1'b1;
               rsp_status_in = fin_status;
               rsp_pay_in = fin_pay;
               mem_we = fin_write;
               mem_wdata = fin_entry;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // item and result registers
   always_ff @(posedge clock) begin
      hcnt_ff <= hcnt_in;
      cnt_ff <= cnt_in;
      cmd_ff <= cmd_in;
      key_ff <= key_in;
      pay_ff <= pay_in;
      acc_ff <= acc_in;
      slot_ff <= slot_in;
      step_ff <= step_in;
      rsp_status_ff <= rsp_status_in;
      rsp_pay_ff <= rsp_pay_in;
   end

   // slot memory, one write and one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         slot_mem_ff[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= slot_mem_ff[slot_ff];
      end
   end

   // an accepted item closes the input until its result is loaded
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_tready)
      else $error("input open while an item is in flight");

   // a loaded result returns the sequencer to idle
   a_idle_after_load: assert property (@(posedge clock) disable iff (reset)
      rsp_load |=> (state_ff == S_IDLE) && rsp_valid_ff)
      else $error("result load did not return to idle");

   // probe position stays inside the table
   a_slot_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CHECK) |-> ({1'b0, slot_ff} < SLOTS_X) && ({1'b0, step_ff} < SLOTS_X))
      else $error("probe slot out of range");

   // result register is not overwritten while it waits
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |-> !rsp_load)
      else $error("pending result overwritten");

endmodule

`default_nettype wire

/* bench/quadratic_probe_hash_table_test.sv */
`timescale 1ns / 1ps

module quadratic_probe_hash_table_test;
   import qpht_pkg::*;

   localparam int unsigned SLOTS = TABLE_SLOTS_DEF;
   localparam int unsigned PROBE_LIMIT = PROBE_FACTOR * SLOTS;
   localparam logic [CMD_W-1:0] CMD_RESERVED = 2'd3;
   localparam int RANDOM_ITEMS = 1200;
   localparam int LONG_HOLD = 600;
   // one item that runs the whole probe budget, plus some slack
   localparam int SETTLE_CYCLES = 1 + HASH_CYCLES + 2 * PROBE_LIMIT + 20;

   // packed so that the command lands in the lowest bits of tdata
   typedef struct packed {
      logic [PAY_W-1:0] payload;
      logic [KEY_W-1:0] key;
      logic [CMD_W-1:0] command;
   } command_item_type;

   typedef struct {
      status_type       status;
      logic [PAY_W-1:0] payload;
   } lookup_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [71:0] req_tdata = '0;   // command, key, payload_in
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;        // status, payload_out

   quadratic_probe_hash_table #(.TABLE_SLOTS(SLOTS)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #5 clock = ~clock;

   // shadow copy of the slot memory
   logic             shadow_used [SLOTS] = '{default: 1'b0};
   logic [KEY_W-1:0] shadow_key [SLOTS] = '{default: '0};
   logic [PAY_W-1:0] shadow_payload [SLOTS] = '{default: '0};

   command_item_type  pending_items[$];
   lookup_result_type expected_results[$];

   int error_count = 0;
   int command_tally [4] = '{default: 0};
   int status_tally [4] = '{default: 0};
   int long_stall_requests = 0;
   int long_stall_served = 0;
   int clear_passes = 0;

   function automatic int unsigned probe_slot(logic [KEY_W-1:0] k, int unsigned i);
      return ((32'(k) % SLOTS) + (i * i) % SLOTS) % SLOTS;
   endfunction

   // first slot on the probe path holding the key, stopping at a free slot
   function automatic bit locate_key(logic [KEY_W-1:0] k, output int unsigned slot);
      int unsigned s;
      slot = 0;
      for (int unsigned i = 0; i < PROBE_LIMIT; i++) begin
         s = probe_slot(k, i);
         if (!shadow_used[s]) return 1'b0;
         if (shadow_key[s] == k) begin
            slot = s;
            return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   // applies one command to the shadow table and returns its outcome
   function automatic lookup_result_type run_table_command(command_item_type c);
      lookup_result_type r;
      int unsigned s;
      r.status = ST_ABSENT;
      r.payload = '0;
      case (c.command)
         CMD_INSERT: begin
            r.status = ST_FULL;
            for (int unsigned i = 0; i < PROBE_LIMIT; i++) begin
               s = probe_slot(c.key, i);
               if (!shadow_used[s]) begin
                  shadow_used[s] = 1'b1;
                  shadow_key[s] = c.key;
                  shadow_payload[s] = c.payload;
                  r.status = ST_DONE;
                  break;
               end
               if (shadow_key[s] == c.key) begin
                  r.status = ST_DUP;
                  break;
               end
            end
         end
         CMD_SEARCH, CMD_REMOVE: begin
            if (locate_key(c.key, s)) begin
               r.status = ST_DONE;
               r.payload = shadow_payload[s];
               if (c.command == CMD_REMOVE) shadow_used[s] = 1'b0;
            end
         end
         default: ;
      endcase
      command_tally[c.command]++;
      status_tally[r.status]++;
      return r;
   endfunction

   // mostly short idles, now and then a long one
   function automatic int idle_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // sender: offers queued items, predicts each one as it is taken
   int  send_gap = 0;
   int  send_stretch = 0;
   bit  send_quiet = 1'b0;

   always @(posedge clock) begin
      lookup_result_type predicted;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            predicted = run_table_command(
               command_item_type'(req_tdata[PAY_W+KEY_W+CMD_W-1:0]));
            expected_results.push_back(predicted);
         end
         if (!req_tvalid || req_tready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_tvalid <= 1'b0;
            end else if (pending_items.size() > 0) begin
               req_tdata <= {7'b0, pending_items.pop_front()};
               req_tvalid <= 1'b1;
               if (send_stretch == 0) begin
                  send_stretch = $urandom_range(20, 150);
                  send_quiet = ($urandom_range(0, 3) == 0);
               end
               send_stretch--;
               send_gap = send_quiet ? 0 : idle_length();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // receiver: checks each result item against the oldest prediction
   int  recv_hold = 0;
   int  recv_stretch = 0;
   bit  recv_quiet = 1'b0;

   always @(posedge clock) begin
      lookup_result_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_results.size() == 0) begin
               $error("result item with nothing outstanding: status %0d payload_out %h",
                      rsp_tdata[1:0], rsp_tdata[33:2]);
               error_count++;
            end else begin
               want = expected_results.pop_front();
               if (rsp_tdata[1:0] !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_tdata[1:0]);
                  error_count++;
               end
               if (rsp_tdata[33:2] !== want.payload) begin
                  $error("payload_out: expected %h, got %h", want.payload, rsp_tdata[33:2]);
                  error_count++;
               end
            end
         end
         if (long_stall_served != long_stall_requests) begin
            long_stall_served++;
            recv_hold = LONG_HOLD;
         end
         if (recv_stretch == 0) begin
            recv_stretch = $urandom_range(100, 800);
            recv_quiet = ($urandom_range(0, 3) == 0);
         end
         recv_stretch--;
         if (recv_hold > 0) begin
            recv_hold--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if (!recv_quiet && $urandom_range(0, 4) == 0) recv_hold = idle_length();
         end
      end
   end

   task automatic offer(logic [CMD_W-1:0] cmd, logic [KEY_W-1:0] k, logic [PAY_W-1:0] p);
      command_item_type c;
      c.command = cmd;
      c.key = k;
      c.payload = p;
      pending_items.push_back(c);
   endtask

   // sender pause: everything taken and every result back
   task automatic wait_drained();
      do @(negedge clock);
      while (pending_items.size() != 0 || req_tvalid || expected_results.size() != 0);
   endtask

   function automatic int table_fill();
      int n;
      n = 0;
      foreach (shadow_used[s]) if (shadow_used[s]) n++;
      return n;
   endfunction

   // keys with bit 30 set and a chosen home slot, used to plug holes
   function automatic logic [KEY_W-1:0] filler_key(int unsigned home);
      return KEY_W'(((32'($urandom) & 32'h003F_FFFF) | 32'h0040_0000) * SLOTS + home);
   endfunction

   // fresh keys: half clustered around one home slot, some at the extremes
   function automatic logic [KEY_W-1:0] fresh_key(int unsigned cluster);
      int r;
      r = $urandom_range(0, 9);
      if (r < 5)
         return KEY_W'((32'($urandom) & 32'h007F_FFFF) * SLOTS
                       + (cluster + $urandom_range(0, 15)) % SLOTS);
      if (r < 9) return KEY_W'($urandom);
      case ($urandom_range(0, 2))
         0: return '0;
         1: return '1;
         default: return KEY_W'($urandom_range(0, 1023));
      endcase
   endfunction

   function automatic logic [PAY_W-1:0] random_payload();
      int r;
      r = $urandom_range(0, 19);
      if (r == 0) return '0;
      if (r == 1) return '1;
      return $urandom;
   endfunction

   function automatic int distinct_probe_slots();
      bit seen [SLOTS];
      int n;
      n = 0;
      foreach (seen[s]) seen[s] = 1'b0;
      for (int unsigned i = 0; i < PROBE_LIMIT; i++) begin
         if (!seen[(i * i) % SLOTS]) begin
            seen[(i * i) % SLOTS] = 1'b1;
            n++;
         end
      end
      return n;
   endfunction

   // empties the table by removes, deepest entries first; entries cut off
   // by a freed slot get a filler key parked in the hole to reach them again
   task automatic clear_table();
      int unsigned depth [SLOTS];
      bit          plugged [SLOTS];
      int unsigned p;
      int unsigned s;
      int          max_depth;
      clear_passes++;
      for (int round = 0; round < 16 && table_fill() > 0; round++) begin
         max_depth = -1;
         foreach (plugged[h]) plugged[h] = 1'b0;
         for (s = 0; s < SLOTS; s++) begin
            depth[s] = PROBE_LIMIT;
            if (!shadow_used[s]) continue;
            for (int unsigned i = 0; i < PROBE_LIMIT; i++) begin
               p = probe_slot(shadow_key[s], i);
               if (p == s) begin
                  depth[s] = i;
                  break;
               end
               if (!shadow_used[p]) begin
                  if (!plugged[p]) begin
                     plugged[p] = 1'b1;
                     offer(CMD_INSERT, filler_key(p), random_payload());
                  end
                  break;
               end
               // an earlier copy of the same key goes first
               if (shadow_key[p] == shadow_key[s]) break;
            end
            if (depth[s] != PROBE_LIMIT && int'(depth[s]) > max_depth) max_depth = depth[s];
         end
         for (int d = max_depth; d >= 0; d--)
            for (s = 0; s < SLOTS; s++)
               if (depth[s] == d) offer(CMD_REMOVE, shadow_key[s], random_payload());
         wait_drained();
      end
   endtask

   // stimulus
   initial begin
      logic [KEY_W-1:0] known_keys[$];
      logic [KEY_W-1:0] k;
      int unsigned      home;
      int unsigned      base;
      int unsigned      found;
      int               chain;
      int               cluster;
      int               span;
      int               phase;
      int               random_sent;
      int               r;
      int               insert_weight;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: extremes, collisions, duplicates, broken chains, unused code
      offer(CMD_SEARCH, '0, '0);
      offer(CMD_INSERT, '0, '0);
      offer(CMD_INSERT, '0, '1);
      offer(CMD_SEARCH, '0, '1);
      offer(CMD_INSERT, '1, '1);
      offer(CMD_SEARCH, '1, '0);
      offer(CMD_INSERT, KEY_W'(SLOTS), 32'hA5A5_A5A5);
      offer(CMD_INSERT, KEY_W'(2 * SLOTS), 32'h5A5A_5A5A);
      offer(CMD_SEARCH, KEY_W'(2 * SLOTS), '0);
      offer(CMD_REMOVE, KEY_W'(SLOTS), '0);
      offer(CMD_SEARCH, KEY_W'(2 * SLOTS), '0);
      offer(CMD_REMOVE, KEY_W'(2 * SLOTS), '0);
      offer(CMD_INSERT, KEY_W'(2 * SLOTS), 32'h0F0F_F0F0);
      offer(CMD_SEARCH, KEY_W'(2 * SLOTS), '0);
      offer(CMD_REMOVE, '0, '1);
      offer(CMD_RESERVED, '1, '1);
      offer(CMD_RESERVED, '0, '0);
      offer(CMD_REMOVE, '1, '0);
      offer(CMD_SEARCH, 31'h5555_5555, 32'hAAAA_AAAA);
      offer(CMD_INSERT, 31'h2AAA_AAAA, 32'h5555_5555);
      offer(CMD_SEARCH, 31'h2AAA_AAAA, 32'hAAAA_AAAA);
      wait_drained();
      clear_table();

      // fill every slot one home can reach, then run into the probe limit
      home = $urandom_range(0, SLOTS - 1);
      base = $urandom_range(0, 32'h003F_0000);
      chain = distinct_probe_slots();
      for (int j = 0; j < chain + 2; j++)
         offer(CMD_INSERT, KEY_W'((base + j) * SLOTS + home), random_payload());
      k = KEY_W'((base + chain) * SLOTS + home);
      offer(CMD_SEARCH, k, '0);
      offer(CMD_REMOVE, k, '0);
      offer(CMD_INSERT, KEY_W'((base + chain - 1) * SLOTS + home), random_payload());
      offer(CMD_SEARCH, KEY_W'((base + chain - 1) * SLOTS + home), '0);
      offer(CMD_REMOVE, KEY_W'((base + chain / 2) * SLOTS + home), '0);
      offer(CMD_INSERT, k, random_payload());
      offer(CMD_SEARCH, k, '0);
      wait_drained();
      clear_table();

      // random phases of mixed commands over a partly filled table
      phase = 0;
      random_sent = 0;
      while (random_sent < RANDOM_ITEMS) begin
         if (table_fill() > 150 || phase % 8 == 7) clear_table();
         known_keys.delete();
         for (int unsigned s = 0; s < SLOTS; s++)
            if (shadow_used[s] && locate_key(shadow_key[s], found) && found == s)
               known_keys.push_back(shadow_key[s]);
         cluster = $urandom_range(0, SLOTS - 1);
         span = $urandom_range(20, 80);
         if (phase == 2) begin
            // long receiver hold while the sender keeps offering
            span = 90;
            long_stall_requests++;
         end
         insert_weight = table_fill() < 100 ? 50 : (table_fill() < 140 ? 30 : 15);
         for (int n = 0; n < span; n++) begin
            r = $urandom_range(0, 99);
            if (r < insert_weight) begin
               if (known_keys.size() > 0 && $urandom_range(0, 99) < 15) begin
                  k = known_keys[$urandom_range(0, known_keys.size() - 1)];
               end else begin
                  k = fresh_key(cluster);
                  known_keys.push_back(k);
               end
               offer(CMD_INSERT, k, random_payload());
            end else if (r < 95) begin
               if (known_keys.size() > 0 && $urandom_range(0, 99) < 75)
                  k = known_keys[$urandom_range(0, known_keys.size() - 1)];
               else
                  k = fresh_key(cluster);
               offer(r < insert_weight + (95 - insert_weight) / 2 ? CMD_SEARCH : CMD_REMOVE,
                     k, random_payload());
            end else begin
               offer(CMD_RESERVED, KEY_W'($urandom), random_payload());
            end
            random_sent++;
         end
         wait_drained();
         phase++;
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("ran %0d commands: %0d insert, %0d search, %0d remove, %0d unused code",
               command_tally[0] + command_tally[1] + command_tally[2] + command_tally[3],
               command_tally[CMD_INSERT], command_tally[CMD_SEARCH],
               command_tally[CMD_REMOVE], command_tally[CMD_RESERVED]);
      $display("outcomes: %0d done, %0d absent, %0d duplicate, %0d probe limit; %0d clears",
               status_tally[ST_DONE], status_tally[ST_ABSENT], status_tally[ST_DUP],
               status_tally[ST_FULL], clear_passes);
      if (error_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   // watchdog
   initial begin
      #(64'd1_000_000_000);
      $display("CHECK FAILED");
      $finish;
   end

endmodule

/* quadratic_probe_hash_table.f */
rtl/qpht_pkg.sv
rtl/quadratic_probe_hash_table.sv
bench/quadratic_probe_hash_table_test.sv
